>>> hw/rtl/adcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB depth converter package
// Depth and dither codes, register indexes, reset values, dither matrix.
// ----------------------------------------------------------------------------
package adcd_pkg;

  // channel depth codes (code 3 behaves as 16 bits)
  localparam logic [1:0] DEPTH_4  = 2'd0;
  localparam logic [1:0] DEPTH_8  = 2'd1;
  localparam logic [1:0] DEPTH_16 = 2'd2;

  // 8-to-4 path modes (code 3 behaves as plain scaling)
  localparam logic [1:0] DITHER_OFF    = 2'd0;
  localparam logic [1:0] DITHER_HALVED = 2'd1;
  localparam logic [1:0] DITHER_DIRECT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_DEPTH = 2'd0;
  localparam logic [1:0] REG_TARGET_DEPTH = 2'd1;
  localparam logic [1:0] REG_DITHER_MODE  = 2'd2;
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int LINE_W      = 13;
  localparam int CHAN_W      = 16;

  localparam logic [1:0]        RST_SOURCE_DEPTH = DEPTH_8;
  localparam logic [1:0]        RST_TARGET_DEPTH = DEPTH_4;
  localparam logic [1:0]        RST_DITHER_MODE  = DITHER_HALVED;
  localparam logic [LINE_W-1:0] RST_LINE_WIDTH   = 13'd640;

  localparam int ADCD_MAX_LINE_WIDTH = 4096;

  // multiplier constants
  localparam logic [7:0]  K_T249    = 8'd249;    // dither pre-scale
  localparam logic [7:0]  K_DIV17   = 8'd241;    // floor(v/17)   = (v*241) >> 12
  localparam logic [16:0] K_DIV257  = 17'd65281; // floor(v/257)  = (v*65281) >> 24
  localparam logic [19:0] K_DIV4369 = 20'd983056;// floor(v/4369) = (v*983056) >> 32

  // 4x4 ordered dither matrix, index {row[1:0], column[1:0]}
  localparam logic [2:0] DITHER_MATRIX [16] = '{
    3'd0, 3'd4, 3'd1, 3'd5,
    3'd6, 3'd2, 3'd7, 3'd3,
    3'd1, 3'd5, 3'd0, 3'd4,
    3'd7, 3'd3, 3'd6, 3'd2
  };

  // per-pixel position info from the line tracker
  typedef struct packed {
    logic [2:0] dither;
    logic       last;
  } adcd_pos_t;

  // depth settings shared by all lanes
  typedef struct packed {
    logic [1:0] src;
    logic [1:0] dst;
    logic [1:0] mode;
  } adcd_mode_t;

endpackage

>>> hw/rtl/adcd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB depth converter channel lane
// Converts a channel between 4, 8 and 16 bit depths; ordered dither on 8 to 4.
// ----------------------------------------------------------------------------
module adcd_lane
  import adcd_pkg::*;
(
  input  adcd_mode_t        cfg,
  input  logic [2:0]        dither,
  input  logic [CHAN_W-1:0] value,
  output logic [CHAN_W-1:0] result
);

  logic [3:0]  v4;
  logic [7:0]  v8;
  logic [15:0] prod_div17;
  logic [15:0] prod_t249;
  logic [32:0] prod_div257;
  logic [35:0] prod_div4369;
  logic [7:0]  t;
  logic [7:0]  sum_halved;
  logic [7:0]  sum_direct;
  logic [3:0]  down8_4;

  assign v4 = value[3:0];
  assign v8 = value[7:0];

  assign prod_div17   = {8'd0, v8} * {8'd0, K_DIV17};
  assign prod_t249    = {8'd0, v8} * {8'd0, K_T249};
  assign prod_div257  = {17'd0, value} * {16'd0, K_DIV257};
  assign prod_div4369 = {20'd0, value} * {16'd0, K_DIV4369};

  assign t          = prod_t249[15:8];
  assign sum_halved = {1'b0, t[7:1]} + {4'd0, dither, 1'b0};
  assign sum_direct = t + {5'd0, dither};

  always_comb begin
    case (cfg.mode)
      DITHER_HALVED: down8_4 = sum_halved[7:4];
      DITHER_DIRECT: down8_4 = sum_direct[7:4];
      default:       down8_4 = prod_div17[15:12];
    endcase
  end

  always_comb begin
    unique case (cfg.src)
      DEPTH_4: begin
        unique case (cfg.dst)
          DEPTH_4: result = {12'd0, v4};
          DEPTH_8: result = {8'd0, v4, v4};
          default: result = {v4, v4, v4, v4};
        endcase
      end
      DEPTH_8: begin
        unique case (cfg.dst)
          DEPTH_4: result = {12'd0, down8_4};
          DEPTH_8: result = {8'd0, v8};
          default: result = {v8, v8};
        endcase
      end
      default: begin
        unique case (cfg.dst)
          DEPTH_4: result = {12'd0, prod_div4369[35:32]};
          DEPTH_8: result = {8'd0, prod_div257[31:24]};
          default: result = value;
        endcase
      end
    endcase
  end

endmodule

>>> hw/rtl/adcd_position.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB depth converter line tracker
// Column and row phase counters, dither pick and end-of-line flag.
// ----------------------------------------------------------------------------
module adcd_position
  import adcd_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = ADCD_MAX_LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              start_of_image,
  input  logic [LINE_W-1:0] line_width,
  output adcd_pos_t         pos
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int LW = (CW + 1 > LINE_W) ? CW + 1 : LINE_W;
  localparam logic [LW-1:0] MAX_W = LW'(MAX_LINE_WIDTH);

  logic [CW-1:0] column_count;
  logic [1:0]    row_phase;
  logic [CW-1:0] col_cur;
  logic [1:0]    row_cur;
  logic [LW-1:0] width_req;
  logic [LW-1:0] width_eff;

  // start of image restarts the raster before this pixel
  assign col_cur = start_of_image ? '0 : column_count;
  assign row_cur = start_of_image ? 2'd0 : row_phase;

  assign width_req = LW'(line_width);

  always_comb begin
    if (width_req == '0) begin
      width_eff = LW'(1);
    end else if (width_req > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = width_req;
    end
  end

  // at-or-past test also ends the line when the width shrinks mid-line
  assign pos.last   = (LW'(col_cur) >= (width_eff - LW'(1)));
  assign pos.dither = DITHER_MATRIX[{row_cur, col_cur[1:0]}];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_phase    <= 2'd0;
    end else if (advance) begin
      if (pos.last) begin
        column_count <= '0;
        row_phase    <= row_cur + 2'd1;
      end else begin
        column_count <= col_cur + CW'(1);
        row_phase    <= row_cur;
      end
    end
  end

endmodule

>>> hw/rtl/argb_depth_converter_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB channel depth converter with ordered dither
// One ARGB pixel per transfer in, the same pixel at another depth out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one pixel per transfer, tdata = alpha, red, green, blue
//     (16 bits each, from bit 0 up), tuser = start of image.
//   m_* stream: converted pixel, same tdata layout, tlast = end of line.
//   cfg_*: register writes (0 source depth, 1 target depth, 2 dither mode,
//     3 line width); always ready, write only while the stream is idle.
// Output: m_tvalid is registered and rises in the cycle after an input transfer.
// Throughput: one pixel per clock while m_tready is high. The four channel
//   lanes and the line tracker are all combinational ahead of a single
//   output register, so nothing iterates; the only limit is that register.
// Stall: s_tready drops only while the output register holds a pixel that
//   m_tready has not taken; when it is taken, a new pixel loads in the
//   same cycle, so a steady stream never loses a beat.
// Reset: rst (synchronous) empties the output register, clears the column
//   and row counters and loads 8-bit source, 4-bit target, halved dither,
//   640-pixel lines.
// ----------------------------------------------------------------------------
module argb_depth_converter_dither
  import adcd_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = ADCD_MAX_LINE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // input pixels
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [4*CHAN_W-1:0]    s_tdata,   // in_alpha, in_red, in_green, in_blue
  input  logic                   s_tuser,   // start_of_image
  // output pixels
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [4*CHAN_W-1:0]    m_tdata,   // out_alpha, out_red, out_green, out_blue
  output logic                   m_tlast,   // end_of_line
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [1:0]        source_depth;
  logic [1:0]        target_depth;
  logic [1:0]        dither_mode;
  logic [LINE_W-1:0] line_width;

  adcd_mode_t        mode;
  adcd_pos_t         pos;
  logic              in_xfer;
  logic [CHAN_W-1:0] lane_out [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_depth <= RST_SOURCE_DEPTH;
      target_depth <= RST_TARGET_DEPTH;
      dither_mode  <= RST_DITHER_MODE;
      line_width   <= RST_LINE_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_DEPTH: source_depth <= cfg_data[1:0];
        REG_TARGET_DEPTH: target_depth <= cfg_data[1:0];
        REG_DITHER_MODE:  dither_mode  <= cfg_data[1:0];
        REG_LINE_WIDTH:   line_width   <= cfg_data[LINE_W-1:0];
      endcase
    end
  end

  assign mode.src  = source_depth;
  assign mode.dst  = target_depth;
  assign mode.mode = dither_mode;

  // output register free, or being emptied this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  adcd_position #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_position (
    .clk            (clk),
    .rst            (rst),
    .advance        (in_xfer),
    .start_of_image (s_tuser),
    .line_width     (line_width),
    .pos            (pos)
  );

  // one lane per channel, all sharing the same dither value
  for (genvar i = 0; i < 4; i++) begin : g_lane
    adcd_lane u_lane (
      .cfg    (mode),
      .dither (pos.dither),
      .value  (s_tdata[i*CHAN_W +: CHAN_W]),
      .result (lane_out[i])
    );
  end

  // merge stage: lanes and end-of-line flag into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {lane_out[3], lane_out[2], lane_out[1], lane_out[0]};
      m_tlast <= pos.last;
    end
  end

endmodule

>>> hw/rtl/adcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB depth converter port checker
// Checks output register behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module adcd_checker
  import adcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [4*CHAN_W-1:0]    m_tdata,
  input logic                   m_tlast
);

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // accepted pixel shows up the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted pixel not presented");

  // an empty output register never back-pressures
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // no output without an input transfer behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("output appeared without input");

endmodule

bind argb_depth_converter_dither adcd_checker u_adcd_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARGB depth converter testbench
// A table of directed pixels and register writes, then random pixel streams
// over many register settings. Every output transfer is checked field by
// field against a hand-written result or the in-bench pixel conversion model.
// ----------------------------------------------------------------------------
module tb_top;
  import adcd_pkg::*;

  // reserved codes, not named in the package
  localparam logic [1:0] DEPTH_RSVD  = 2'd3;
  localparam logic [1:0] DITHER_RSVD = 2'd3;

  localparam int WIDTH_CAP  = 4096;  // effective line width ceiling
  localparam int IDLE_LIMIT = 2000;  // cycles without any transfer
  localparam int HOLD_AT    = 700;   // pixels in before the long output hold
  localparam int HOLD_LEN   = 300;
  localparam int SEG_PIXELS = 100;   // pixels per random register setting
  localparam int SEG_COUNT  = 6;     // settings per idling phase

  // 4x4 ordered dither, entry i = {row, column} at bits [3*i +: 3]
  localparam logic [47:0] BAYER = {
    3'd2, 3'd6, 3'd3, 3'd7,
    3'd4, 3'd0, 3'd5, 3'd1,
    3'd3, 3'd7, 3'd2, 3'd6,
    3'd5, 3'd1, 3'd4, 3'd0
  };

  typedef struct packed {
    logic        sof;
    logic [15:0] a, r, g, b;
  } pixel_t;

  typedef struct packed {
    logic [15:0] a, r, g, b;
    logic        eol;
  } argb_t;

  typedef enum logic { ROW_REG, ROW_PIXEL } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [12:0] val;
    pixel_t      px;
    logic        typed;  // want holds a hand-written result
    argb_t       want;
  } plan_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [4*CHAN_W-1:0]    s_tdata   = '0;  // alpha, red, green, blue
  logic                   s_tuser   = 1'b0;  // start of image
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [4*CHAN_W-1:0]    m_tdata;          // alpha, red, green, blue
  logic                   m_tlast;          // end of line
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // conversion model state and registers
  logic [1:0]  cur_src   = DEPTH_8;
  logic [1:0]  cur_dst   = DEPTH_4;
  logic [1:0]  cur_mode  = DITHER_HALVED;
  logic [12:0] cur_width = 13'd640;
  int unsigned col_q     = 0;
  logic [1:0]  row_q     = 2'd0;

  argb_t pending_pixels[$];

  int pixels_in     = 0;
  int results_seen  = 0;
  int line_ends     = 0;
  int reg_writes    = 0;
  int mismatches    = 0;
  int src_gap_pct   = 0;
  int sink_gap_pct  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  argb_depth_converter_dither uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Conversion model
  // --------------------------------------------------------------------------
  function automatic logic [15:0] convert_chan(input logic [15:0] raw,
                                               input logic [1:0] s, t,
                                               input int unsigned d);
    longint unsigned v, res, scaled;
    res = 0;
    case (s)
      DEPTH_4: begin
        v = raw[3:0];
        case (t)
          DEPTH_4: res = v;
          DEPTH_8: res = v * 255 / 15;
          default: res = v * 65535 / 15;
        endcase
      end
      DEPTH_8: begin
        v = raw[7:0];
        case (t)
          DEPTH_4: begin
            // 8 -> 4 is the only path the dither setting touches
            scaled = (v * 249) >> 8;
            if (cur_mode == DITHER_HALVED) res = ((scaled >> 1) + (d << 1)) >> 4;
            else if (cur_mode == DITHER_DIRECT) res = (scaled + d) >> 4;
            else res = v * 15 / 255;
          end
          DEPTH_8: res = v;
          default: res = v * 65535 / 255;
        endcase
      end
      default: begin
        v = raw;
        case (t)
          DEPTH_4: res = v * 15 / 65535;
          DEPTH_8: res = v * 255 / 65535;
          default: res = v;
        endcase
      end
    endcase
    return res[15:0];
  endfunction

  // converts one pixel and steps the column / row tracker
  function automatic argb_t convert_pixel(input pixel_t px);
    argb_t       res;
    logic [1:0]  s, t;
    int unsigned span, idx, d;
    s = (cur_src == DEPTH_RSVD) ? DEPTH_16 : cur_src;
    t = (cur_dst == DEPTH_RSVD) ? DEPTH_16 : cur_dst;
    span = cur_width;
    if (span < 1) span = 1;
    if (span > WIDTH_CAP) span = WIDTH_CAP;
    if (px.sof) begin
      col_q = 0;
      row_q = 2'd0;
    end
    idx = row_q * 4 + col_q % 4;
    d = BAYER[3*idx +: 3];
    res.a = convert_chan(px.a, s, t, d);
    res.r = convert_chan(px.r, s, t, d);
    res.g = convert_chan(px.g, s, t, d);
    res.b = convert_chan(px.b, s, t, d);
    // a width shrunk below the current column ends the line at once
    res.eol = (col_q >= span - 1);
    if (res.eol) begin
      col_q = 0;
      row_q = row_q + 2'd1;
    end else begin
      col_q = col_q + 1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table rows
  // --------------------------------------------------------------------------
  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [12:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  function automatic plan_row_t pix_row(input logic sof, input logic [15:0] a, r, g, b);
    plan_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.px = '{sof: sof, a: a, r: r, g: g, b: b};
    return row;
  endfunction

  function automatic plan_row_t pix_known(input logic sof, input logic [15:0] a, r, g, b,
                                          input logic [15:0] ea, er, eg, eb,
                                          input logic eeol);
    plan_row_t row;
    row = pix_row(sof, a, r, g, b);
    row.typed = 1'b1;
    row.want = '{a: ea, r: er, g: eg, b: eb, eol: eeol};
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Random content
  // --------------------------------------------------------------------------
  function automatic logic [15:0] random_chan();
    logic [15:0] v;
    case ($urandom_range(9))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2, 3, 4: begin
        // stay inside the source range
        if (cur_src == DEPTH_4) v = 16'($urandom_range(15));
        else if (cur_src == DEPTH_8) v = 16'($urandom_range(255));
        else v = 16'($urandom);
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.sof = ($urandom_range(99) < 3);
    px.a = random_chan();
    px.r = random_chan();
    px.g = random_chan();
    px.b = random_chan();
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      REG_SOURCE_DEPTH: cur_src = val[1:0];
      REG_TARGET_DEPTH: cur_dst = val[1:0];
      REG_DITHER_MODE:  cur_mode = val[1:0];
      REG_LINE_WIDTH:   cur_width = val;
      default: ;
    endcase
  endtask

  // valid stays high from one pixel to the next unless a gap is drawn
  task automatic send_pixel(input pixel_t px, input logic typed, input argb_t want);
    argb_t model_out;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {px.b, px.g, px.r, px.a};
    s_tuser  <= px.sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_out = convert_pixel(px);
    pending_pixels.push_back(typed ? want : model_out);
    pixels_in++;
  endtask

  // registers change only with the pipe empty
  task automatic drain_and_pause();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_setting();
    logic [1:0]  src, dst;
    logic [12:0] width;
    // lean toward the 8 -> 4 path, where the dither lives
    if ($urandom_range(1) == 0) src = DEPTH_8;
    else src = 2'($urandom_range(3));
    if (src == DEPTH_8 && $urandom_range(9) < 6) dst = DEPTH_4;
    else dst = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: width = 13'd0;
      1: width = 13'h1FFF;
      2: width = 13'd4096;
      3: width = 13'd1;
      default: width = 13'($urandom_range(24, 2));
    endcase
    write_reg(REG_SOURCE_DEPTH, 13'(src));
    write_reg(REG_TARGET_DEPTH, 13'(dst));
    write_reg(REG_DITHER_MODE, 13'($urandom_range(3)));
    write_reg(REG_LINE_WIDTH, width);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d, %s: got %0h, want %0h",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random ready, plus one long hold so the input backs up
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && pixels_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // result checker, samples pre-edge values
  always @(posedge clk) begin : check_results
    argb_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tlast) line_ends++;
      if (pending_pixels.size() == 0) begin
        flag_mismatch("transfer with nothing pending", m_tdata[15:0], 0);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[15:0] !== want.a) flag_mismatch("alpha", m_tdata[15:0], want.a);
        if (m_tdata[31:16] !== want.r) flag_mismatch("red", m_tdata[31:16], want.r);
        if (m_tdata[47:32] !== want.g) flag_mismatch("green", m_tdata[47:32], want.g);
        if (m_tdata[63:48] !== want.b) flag_mismatch("blue", m_tdata[63:48], want.b);
        if (m_tlast !== want.eol) flag_mismatch("end of line", m_tlast, want.eol);
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan[$];
    plan_row_t row;
    logic      prev_was_pixel;

    // reset defaults: 8-bit in, 4-bit out, halved dither, 640-pixel lines
    plan.push_back(pix_known(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(pix_row(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    plan.push_back(pix_row(0, 16'h00FF, 16'h0080, 16'h0001, 16'hFF00));
    plan.push_back(pix_row(0, 16'h0010, 16'h00F0, 16'h007F, 16'h00C3));
    // width cut below the current column: next pixel closes the line
    plan.push_back(reg_row(REG_LINE_WIDTH, 13'd2));
    plan.push_back(pix_known(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    // 4 -> 16 with dither set (no effect), width 0 behaves as 1
    plan.push_back(reg_row(REG_SOURCE_DEPTH, DEPTH_4));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_16));
    plan.push_back(reg_row(REG_DITHER_MODE, DITHER_DIRECT));
    plan.push_back(reg_row(REG_LINE_WIDTH, 13'd0));
    plan.push_back(pix_known(0, 16'h000F, 16'h0000, 16'hFFF5, 16'h0001,
                             16'hFFFF, 16'h0000, 16'h5555, 16'h1111, 1));
    plan.push_back(pix_row(0, 16'hFFF0, 16'h0008, 16'h000A, 16'h0007));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_8));
    plan.push_back(pix_known(0, 16'h000F, 16'h0001, 16'h0000, 16'h000E,
                             16'h00FF, 16'h0011, 16'h0000, 16'h00EE, 1));
    // 16 -> 4 and 16 -> 8, width above the cap
    plan.push_back(reg_row(REG_SOURCE_DEPTH, DEPTH_16));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_4));
    plan.push_back(reg_row(REG_LINE_WIDTH, 13'h1FFF));
    plan.push_back(pix_known(1, 16'hFFFF, 16'h0000, 16'h8000, 16'h1111,
                             16'h000F, 16'h0000, 16'h0007, 16'h0001, 0));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_8));
    plan.push_back(pix_known(0, 16'hFFFF, 16'h0100, 16'h00FF, 16'h8080,
                             16'h00FF, 16'h0000, 16'h0000, 16'h0080, 0));
    // reserved depth code on both sides: 16 -> 16 pass-through
    plan.push_back(reg_row(REG_SOURCE_DEPTH, DEPTH_RSVD));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_RSVD));
    plan.push_back(pix_known(0, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A,
                             16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A, 0));
    // 8 -> 16, then 8 -> 8 with bits above the source width
    plan.push_back(reg_row(REG_SOURCE_DEPTH, DEPTH_8));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_16));
    plan.push_back(pix_known(0, 16'h00FF, 16'h0001, 16'hFF00, 16'h0080,
                             16'hFFFF, 16'h0101, 16'h0000, 16'h8080, 0));
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_8));
    plan.push_back(pix_known(0, 16'h1234, 16'hFF00, 16'h00FF, 16'hABCD,
                             16'h0034, 16'h0000, 16'h00FF, 16'h00CD, 0));
    // 8 -> 4 in every dither setting, 4-pixel lines
    plan.push_back(reg_row(REG_TARGET_DEPTH, DEPTH_4));
    plan.push_back(reg_row(REG_DITHER_MODE, DITHER_OFF));
    plan.push_back(reg_row(REG_LINE_WIDTH, 13'd4));
    plan.push_back(pix_known(1, 16'h00FF, 16'h0000, 16'h0080, 16'h0011,
                             16'h000F, 16'h0000, 16'h0007, 16'h0001, 0));
    plan.push_back(reg_row(REG_DITHER_MODE, DITHER_HALVED));
    plan.push_back(pix_row(0, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF));
    plan.push_back(pix_row(0, 16'h0080, 16'h0040, 16'h00C0, 16'h0011));
    plan.push_back(pix_row(0, 16'h00FF, 16'h0000, 16'h0001, 16'h00FE));
    plan.push_back(pix_row(0, 16'h00F0, 16'h000F, 16'h0088, 16'h0077));
    plan.push_back(reg_row(REG_DITHER_MODE, DITHER_DIRECT));
    plan.push_back(pix_row(0, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF));
    plan.push_back(pix_row(0, 16'h0080, 16'h0040, 16'h00C0, 16'h0011));
    plan.push_back(pix_row(0, 16'h00FF, 16'h0000, 16'h0001, 16'h00FE));
    plan.push_back(pix_row(0, 16'h00F0, 16'h000F, 16'h0088, 16'h0077));
    // reserved dither code falls back to plain scaling
    plan.push_back(reg_row(REG_DITHER_MODE, DITHER_RSVD));
    plan.push_back(pix_known(0, 16'h00FF, 16'h0000, 16'h0080, 16'h0011,
                             16'h000F, 16'h0000, 16'h0007, 16'h0001, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    src_gap_pct  = 38;
    sink_gap_pct = 48;
    prev_was_pixel = 1'b1;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        if (prev_was_pixel) drain_and_pause();
        write_reg(row.idx, row.val);
        prev_was_pixel = 1'b0;
      end else begin
        if (!prev_was_pixel) cfg_valid <= 1'b0;
        send_pixel(row.px, row.typed, row.want);
        prev_was_pixel = 1'b1;
      end
    end

    // random streams: receiver-heavy gaps, sender-heavy gaps, then none
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_gap_pct = 38; sink_gap_pct = 48; end
        1: begin src_gap_pct = 48; sink_gap_pct = 38; end
        default: begin src_gap_pct = 0; sink_gap_pct = 0; end
      endcase
      for (int sg = 0; sg < SEG_COUNT; sg++) begin
        drain_and_pause();
        random_setting();
        repeat (SEG_PIXELS) send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    drain_and_pause();
    repeat (4) @(posedge clk);

    $display("%0d pixels converted across %0d register writes,", pixels_in, reg_writes);
    $display("%0d results checked, %0d line ends; all depth pairs, dither settings,",
             results_seen, line_ends);
    $display("reserved codes, width limits, %0d-cycle hold", HOLD_LEN);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
